/* design/u8dec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and lead byte decode for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	// Field widths.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CP_W      = 21;
	localparam int unsigned LEN_W     = 3;
	localparam int unsigned PEND_W    = 2;
	localparam int unsigned TDATA_W   = CP_W + LEN_W;
	localparam int unsigned TUSER_W   = 2;

	// Byte masks used by the decode.
	localparam logic [BYTE_W-1:0] CONT_TAG_MASK = 8'hc0;
	localparam logic [BYTE_W-1:0] CONT_TAG      = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'h3f;
	localparam logic [BYTE_W-1:0] MASK_LEN1     = 8'h7f;
	localparam logic [BYTE_W-1:0] MASK_LEN2     = 8'h1f;
	localparam logic [BYTE_W-1:0] MASK_LEN3     = 8'h0f;
	localparam logic [BYTE_W-1:0] MASK_LEN4     = 8'h07;

	// Glyph lengths; zero marks an invalid lead byte.
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	// Positions of the flags in the result tuser.
	localparam int unsigned TUSER_GLYPH_READY  = 0;
	localparam int unsigned TUSER_STRING_VALID = 1;

	// Decoder state carried from byte to byte.
	typedef struct packed {
		logic [PEND_W-1:0] bytes_pending;
		logic [CP_W-1:0]   partial_code;
		logic [LEN_W-1:0]  current_length;
		logic              error_seen;
	} dec_state_t;

	// Glyph length from the top five bits of a lead byte.
	function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] n;
		begin
			if (b[7] == 1'b0) begin
				n = LEN_ONE;
			end else if (b[7:5] == 3'b110) begin
				n = LEN_TWO;
			end else if (b[7:4] == 4'b1110) begin
				n = LEN_THREE;
			end else if (b[7:3] == 5'b11110) begin
				n = LEN_FOUR;
			end else begin
				n = LEN_NONE;
			end
			return n;
		end
	endfunction

	// Payload bits of a lead byte for a given glyph length.
	function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
			input logic [LEN_W-1:0] n);
		logic [BYTE_W-1:0] m;
		begin
			unique case (n)
				LEN_ONE:   m = MASK_LEN1;
				LEN_TWO:   m = MASK_LEN2;
				LEN_THREE: m = MASK_LEN3;
				LEN_FOUR:  m = MASK_LEN4;
				default:   m = '0;
			endcase
			return {{(CP_W-BYTE_W){1'b0}}, b & m};
		end
	endfunction

endpackage
`default_nettype wire

/* design/utf8_stream_decoder_validator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator
// Each input byte passes the input register, then the result register; the
// result is held in the result register while the output stalls.
// Throughput: one byte per cycle unless the output stalls; the decoder state updates in one pass.
// Reset: arst_n clears the decoder state and all valid flags at once.
// Decodes a UTF-8 byte stream into code points and checks it for errors.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_validator
	import u8dec_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input bytes.
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic               s_axis_tlast,   // last_byte
	// Results.
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [TDATA_W-1:0]      m_axis_tdata,   // [20:0] code_point, [23:21] glyph_length
	output logic [TUSER_W-1:0]      m_axis_tuser,   // [0] glyph_ready, [1] string_valid
	output logic                    m_axis_tlast    // string_end
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;

	dec_state_t         state_q;
	dec_state_t         state_d;

	logic               out_valid_q;
	logic [CP_W-1:0]    out_cp_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_ready_q;
	logic               out_end_q;
	logic               out_ok_q;

	logic               advance;
	logic               emit;
	logic               done;
	logic [CP_W-1:0]    cp;
	logic [LEN_W-1:0]   len;
	logic               str_ok;
	logic [LEN_W-1:0]   lead_n;
	logic [PEND_W-1:0]  pend_dec;

	// Stage 1 moves on whenever the result register is free or being drained.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Decode of the registered byte against the current state.
	assign lead_n   = lead_length(byte_s1);
	assign pend_dec = state_q.bytes_pending - 2'd1;

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		cp      = '0;
		len     = LEN_NONE;
		str_ok  = 1'b0;
		if (!state_q.error_seen) begin
			if (state_q.bytes_pending == '0) begin
				if (lead_n == LEN_NONE) begin
					state_d.error_seen = 1'b1;
				end else if (lead_n == LEN_ONE) begin
					done = 1'b1;
					cp   = lead_payload(byte_s1, LEN_ONE);
					len  = LEN_ONE;
				end else begin
					state_d.partial_code   = lead_payload(byte_s1, lead_n);
					state_d.bytes_pending  = PEND_W'(lead_n - LEN_ONE);
					state_d.current_length = lead_n;
				end
			end else if ((byte_s1 & CONT_TAG_MASK) != CONT_TAG) begin
				state_d.error_seen = 1'b1;
			end else begin
				state_d.partial_code  = {state_q.partial_code[CP_W-7:0],
					byte_s1[5:0] & CONT_PAYLOAD[5:0]};
				state_d.bytes_pending = pend_dec;
				if (pend_dec == '0) begin
					done = 1'b1;
					cp   = state_d.partial_code;
					len  = state_q.current_length;
					state_d.partial_code   = '0;
					state_d.current_length = LEN_NONE;
				end
			end
		end
		// The last byte closes the string and always yields a result.
		if (last_s1) begin
			str_ok = !state_d.error_seen && (state_d.bytes_pending == '0);
			if (!str_ok) begin
				done = 1'b0;
				cp   = '0;
				len  = LEN_NONE;
			end
			state_d = '0;
		end
	end

	assign emit = valid_s1 && (done || last_s1);

	// Decoder state advances once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_cp_q    <= cp;
			out_len_q   <= len;
			out_ready_q <= done;
			out_end_q   <= last_s1;
			out_ok_q    <= str_ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_cp_q};
	assign m_axis_tlast  = out_end_q;
	always_comb begin
		m_axis_tuser                     = '0;
		m_axis_tuser[TUSER_GLYPH_READY]  = out_ready_q;
		m_axis_tuser[TUSER_STRING_VALID] = out_ok_q;
	end

	// A completed glyph always has a nonzero length.
	a_glyph_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready_q) |-> (out_len_q != LEN_NONE))
		else $error("glyph result with zero length");

	// Only a result that closes the string may report it valid; a mid-string result always carries a glyph.
	a_valid_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_end_q) |-> (!out_ok_q && out_ready_q))
		else $error("mid-string result without a glyph or with a valid flag");

	// A result without a glyph carries zero code point and length.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready_q) |-> (out_cp_q == '0 && out_len_q == LEN_NONE))
		else $error("empty result carries glyph bits");

	// While continuation bytes are pending, the glyph length exceeds them.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.bytes_pending != '0) |->
		(state_q.current_length > {1'b0, state_q.bytes_pending}))
		else $error("pending count inconsistent with glyph length");

endmodule
`default_nettype wire

/* sim/tb_utf8_stream_decoder_validator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_validator
// Drives UTF-8 byte strings into the decoder and checks every result transfer
// against a cycle-free model of the decode. A short directed set covers the
// glyph length extremes, overlong and surrogate forms, bad lead bytes, bad
// continuation bytes and truncated strings. Random strings follow, mostly
// well formed, under three idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_validator;
	import u8dec_pkg::*;

	localparam int unsigned BYTES_PER_PHASE = 350;
	localparam int unsigned WATCHDOG_LIMIT  = 3000;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned DRAIN_CYCLES    = 8;

	// One decoder result as the stream carries it.
	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] glyph_length;
		logic             glyph_ready;
		logic             string_end;
		logic             string_valid;
	} glyph_result_t;

	// Tracks the decoder state and the results still owed by the block.
	class glyph_scoreboard;
		logic [PEND_W-1:0] cont_left;
		logic [CP_W-1:0]   code_acc;
		logic [LEN_W-1:0]  glyph_len;
		logic              bad_string;
		glyph_result_t     owed_glyphs[$];
		int                failures;

		function new();
			cont_left  = '0;
			code_acc   = '0;
			glyph_len  = '0;
			bad_string = 1'b0;
			failures   = 0;
		endfunction

		// Length of the glyph that a lead byte opens.
		function logic [LEN_W-1:0] lead_glyph_len(input logic [BYTE_W-1:0] b);
			casez (b[7:3])
				5'b0????: return LEN_ONE;
				5'b110??: return LEN_TWO;
				5'b1110?: return LEN_THREE;
				5'b11110: return LEN_FOUR;
				default:  return LEN_NONE;
			endcase
		endfunction

		// Steps the decode over one input transfer.
		function void note_byte(input logic [BYTE_W-1:0] b, input logic last);
			glyph_result_t    r;
			logic             done;
			logic [LEN_W-1:0] n;
			logic [BYTE_W-1:0] m;
			r = '0;
			done = 1'b0;
			if (!bad_string) begin
				if (cont_left == '0) begin
					n = lead_glyph_len(b);
					case (n)
						LEN_NONE: bad_string = 1'b1;
						LEN_ONE: begin
							done = 1'b1;
							r.code_point = CP_W'(b & MASK_LEN1);
							r.glyph_length = LEN_ONE;
						end
						default: begin
							case (n)
								LEN_TWO:   m = MASK_LEN2;
								LEN_THREE: m = MASK_LEN3;
								default:   m = MASK_LEN4;
							endcase
							code_acc  = CP_W'(b & m);
							cont_left = PEND_W'(n - LEN_ONE);
							glyph_len = n;
						end
					endcase
				end else if ((b & CONT_TAG_MASK) != CONT_TAG) begin
					// A bad continuation byte is not read again as a lead.
					bad_string = 1'b1;
				end else begin
					code_acc  = {code_acc[CP_W-7:0], b[5:0]};
					cont_left = cont_left - PEND_W'(1);
					if (cont_left == '0) begin
						done = 1'b1;
						r.code_point = code_acc;
						r.glyph_length = glyph_len;
						code_acc  = '0;
						glyph_len = '0;
					end
				end
			end
			// The last byte always closes the string with one result.
			if (last) begin
				r.string_end = 1'b1;
				r.string_valid = !bad_string && (cont_left == '0);
				if (!r.string_valid) begin
					done = 1'b0;
					r.code_point = '0;
					r.glyph_length = '0;
				end
				r.glyph_ready = done;
				owed_glyphs.push_back(r);
				cont_left  = '0;
				code_acc   = '0;
				glyph_len  = '0;
				bad_string = 1'b0;
			end else if (done) begin
				r.glyph_ready = 1'b1;
				owed_glyphs.push_back(r);
			end
		endfunction

		function void compare_field(input string field, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
				failures++;
			end
		endfunction

		// Checks one output transfer against the oldest owed result.
		function void check_result(input logic [TDATA_W-1:0] tdata,
				input logic [TUSER_W-1:0] tuser, input logic tlast);
			glyph_result_t r;
			if (owed_glyphs.size() == 0) begin
				$error("unexpected result transfer: tdata 0x%0h tuser 0x%0h tlast %0b",
					tdata, tuser, tlast);
				failures++;
			end else begin
				r = owed_glyphs.pop_front();
				compare_field("code_point", 32'(r.code_point), 32'(tdata[CP_W-1:0]));
				compare_field("glyph_length", 32'(r.glyph_length),
					32'(tdata[TDATA_W-1:CP_W]));
				compare_field("glyph_ready", 32'(r.glyph_ready),
					32'(tuser[TUSER_GLYPH_READY]));
				compare_field("string_valid", 32'(r.string_valid),
					32'(tuser[TUSER_STRING_VALID]));
				compare_field("string_end", 32'(r.string_end), 32'(tlast));
			end
		endfunction

		function bit drained();
			return owed_glyphs.size() == 0;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [BYTE_W-1:0]   s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [TUSER_W-1:0]  m_axis_tuser;
	logic                m_axis_tlast;

	glyph_scoreboard sb = new();
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_idle_pct = 0;
	int unsigned     bytes_sent = 0;
	int unsigned     quiet_cycles = 0;
	bit              hold_asked = 1'b0;
	bit              hold_given = 1'b0;
	int unsigned     hold_left = 0;

	utf8_stream_decoder_validator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver ready: one long hold-off when asked, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_asked && !hold_given) begin
			hold_given = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Transfers are sampled on the falling edge before the rising edge that completes them.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
		end
		$display("status: fail");
		$finish;
	end

	// Offers one byte, sometimes after a random idle gap, and waits for its transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do begin
			@(negedge clk);
		end while (!s_axis_tready);
		@(posedge clk);
		bytes_sent++;
	endtask

	// One random string: mostly well formed, some corrupted or cut short, some raw noise.
	task automatic send_random_string();
		logic [BYTE_W-1:0] str[$];
		int unsigned       kind;
		int unsigned       n;
		int unsigned       pos;
		kind = $urandom_range(99);
		if (kind < 15) begin
			repeat ($urandom_range(1, 6)) str.push_back(BYTE_W'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				n = $urandom_range(1, 4);
				case (n)
					1: str.push_back(BYTE_W'($urandom_range(8'h7f)));
					2: str.push_back(8'hc0 | BYTE_W'($urandom_range(8'h1f)));
					3: str.push_back(8'he0 | BYTE_W'($urandom_range(8'h0f)));
					default: str.push_back(8'hf0 | BYTE_W'($urandom_range(8'h07)));
				endcase
				repeat (n - 1) str.push_back(CONT_TAG | BYTE_W'($urandom_range(8'h3f)));
			end
			if (kind < 27) begin
				// Overwrite one byte with anything.
				pos = $urandom_range(str.size() - 1);
				str[pos] = BYTE_W'($urandom_range(255));
			end else if (kind < 35 && str.size() > 1) begin
				// Cut the string short, often inside a glyph.
				void'(str.pop_back());
			end
		end
		foreach (str[i]) begin
			send_byte(str[i], i == str.size() - 1);
		end
	endtask

	initial begin
		// Bit 8 of each entry marks the last byte of a string.
		logic [8:0] directed_bytes[$];
		directed_bytes = '{
			9'h000, 9'h17f,                         // zero byte and largest one-byte glyph
			9'h0c0, 9'h080, 9'h0df, 9'h1bf,         // overlong and largest two-byte glyph
			9'h0ef, 9'h0bf, 9'h0bf,                 // largest three-byte glyph
			9'h0ed, 9'h0a0, 9'h180,                 // surrogate, accepted
			9'h0f7, 9'h0bf, 9'h0bf, 9'h1bf,         // largest four-byte payload
			9'h080, 9'h141,                         // continuation byte as lead
			9'h1ff,                                 // invalid lead on the last byte
			9'h0c3, 9'h041, 9'h1f8,                 // bad continuation, then more bytes
			9'h0e2, 9'h182                          // string ends inside a glyph
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles often, receiver stalls most of the time.
		send_idle_pct = 23;
		recv_idle_pct = 75;
		foreach (directed_bytes[i]) begin
			send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
		end
		while (bytes_sent < BYTES_PER_PHASE) send_random_string();

		// The other way round.
		send_idle_pct = 75;
		recv_idle_pct = 23;
		while (bytes_sent < 2 * BYTES_PER_PHASE) send_random_string();

		// Full rate, with one long output hold-off to fill the block.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asked = 1'b1;
		while (bytes_sent < 3 * BYTES_PER_PHASE) send_random_string();
		s_axis_tvalid <= 1'b0;

		while (!sb.drained()) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.drained()) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
